// ----- design/tpd_pkg.sv -----
// Package for the triangle pixel depth test.
// Holds payload structs, datapath widths and the control state type.
// Depends on nothing; every design file imports it.
package tpd_pkg;

   localparam int COORD_W  = 9;
   localparam int DEPTH_W  = 8;
   localparam int COLOUR_W = 32;
   // Doubled area of three 9-bit points fits 23 signed bits.
   localparam int AREA_W   = 23;
   // A sub-area of an inside pixel never exceeds the total, below 2^20.
   localparam int WEIGHT_W = 20;
   // Weighted sum of three sub-areas times 8-bit depths.
   localparam int NUM_W    = 30;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic [COORD_W-1:0]  vert_a_x;
      logic [COORD_W-1:0]  vert_a_y;
      logic [DEPTH_W-1:0]  vert_a_depth;
      logic [COORD_W-1:0]  vert_b_x;
      logic [COORD_W-1:0]  vert_b_y;
      logic [DEPTH_W-1:0]  vert_b_depth;
      logic [COORD_W-1:0]  vert_c_x;
      logic [COORD_W-1:0]  vert_c_y;
      logic [DEPTH_W-1:0]  vert_c_depth;
      logic [COLOUR_W-1:0] fill_colour;
      logic [COORD_W-1:0]  pixel_col;
      logic [COORD_W-1:0]  pixel_row;
   } req_payload_type;

   typedef struct packed {
      logic                pixel_written;
      logic [COORD_W-1:0]  out_col;
      logic [COORD_W-1:0]  out_row;
      logic [COLOUR_W-1:0] out_colour;
      logic [DEPTH_W-1:0]  out_depth;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_NUMER,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

// ----- design/tpd_area.sv -----
// Doubled signed shoelace area of three points.
// Depends on tpd_pkg for the point type and widths.
module tpd_area (
   input  tpd_pkg::point_type               p,
   input  tpd_pkg::point_type               q,
   input  tpd_pkg::point_type               r,
   output logic signed [tpd_pkg::AREA_W-1:0] area
);
   import tpd_pkg::*;

   logic signed [COORD_W:0]   dy_pq, dy_qr, dy_rp;
   logic signed [COORD_W+1:0] sx_pq, sx_qr, sx_rp;
   logic signed [2*COORD_W+2:0] prod_pq, prod_qr, prod_rp;

   // Edge height differences and column sums.
   always_comb begin
      dy_pq = $signed({1'b0, q.y}) - $signed({1'b0, p.y});
      dy_qr = $signed({1'b0, r.y}) - $signed({1'b0, q.y});
      dy_rp = $signed({1'b0, p.y}) - $signed({1'b0, r.y});
      sx_pq = $signed({2'b00, q.x}) + $signed({2'b00, p.x});
      sx_qr = $signed({2'b00, r.x}) + $signed({2'b00, q.x});
      sx_rp = $signed({2'b00, p.x}) + $signed({2'b00, r.x});
   end

   // Three trapezoid terms summed into the doubled area.
   always_comb begin
      prod_pq = (2*COORD_W+3)'(dy_pq * sx_pq);
      prod_qr = (2*COORD_W+3)'(dy_qr * sx_qr);
      prod_rp = (2*COORD_W+3)'(dy_rp * sx_rp);
      area = AREA_W'(prod_pq) + AREA_W'(prod_qr) + AREA_W'(prod_rp);
   end

endmodule

// ----- design/tpd_divider.sv -----
// Restoring divider giving an 8-bit quotient, one bit per cycle.
// Depends on tpd_pkg for widths. The quotient must fit in 8 bits.
module tpd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tpd_pkg::NUM_W-1:0]     numer,
   input  logic [tpd_pkg::WEIGHT_W-1:0]  denom,
   output logic                          done,
   output logic [tpd_pkg::DEPTH_W-1:0]   quot
);
   import tpd_pkg::*;

   localparam int CNT_W = $clog2(DEPTH_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [WEIGHT_W-1:0] den_ff, den_in;
   logic [DEPTH_W-1:0]  quot_ff, quot_in;
   logic [NUM_W-1:0]    trial;
   logic                fits;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      trial   = NUM_W'(den_ff) << cnt_ff;
      fits    = rem_ff >= trial;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DEPTH_W - 1);
         rem_in  = numer;
         den_in  = denom;
         quot_in = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DEPTH_W-2:0], fits};
         if (fits) begin
            rem_in = rem_ff - trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- design/tpd_depth_store.sv -----
// Depth store: one-port-read, one-port-write synchronous memory of depths.
// Clears itself after reset, one entry per cycle. Depends on tpd_pkg.
module tpd_depth_store #(
   parameter int DEPTH  = 262144,
   parameter int ADDR_W = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [tpd_pkg::DEPTH_W-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [tpd_pkg::DEPTH_W-1:0]  wr_data,
   output logic                         clear_busy
);
   import tpd_pkg::*;

   logic [DEPTH_W-1:0] mem [DEPTH];
   logic [DEPTH_W-1:0] rd_data_ff;
   logic               clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]  clear_addr_ff, clear_addr_in;
   logic               port_we;
   logic [ADDR_W-1:0]  port_addr;
   logic [DEPTH_W-1:0] port_data;

   // Clearing sweep after reset, then the user write port.
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      port_we   = clear_busy_ff | wr_en;
      port_addr = clear_busy_ff ? clear_addr_ff : wr_addr;
      port_data = clear_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Memory array with registered read data.
   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// ----- design/triangle_pixel_depth_test.sv -----
// Triangle pixel depth test: one candidate pixel per transfer, tested
// against its triangle by doubled shoelace areas, depth-interpolated and
// compared with the depth store. Items are handled one at a time: an inside
// pixel passes from one accepted transfer to the next through the accepting
// state, one shared area unit for the total and the three sub-areas, the
// weighted sum, the bit-serial divider including the hand-over of the
// quotient, and the store update and response. A rejected pixel skips the
// divider. A result held by a low rsp_ready keeps the sequencer in the
// update state. After reset the depth store is swept to zero over all
// SCREEN_WIDTH*SCREEN_HEIGHT entries (262144 at the defaults), during which
// req_ready stays low. Depends on tpd_pkg.
module triangle_pixel_depth_test #(
   parameter int SCREEN_WIDTH  = 512,
   parameter int SCREEN_HEIGHT = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tpd_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tpd_pkg::rsp_payload_type rsp_data
);
   import tpd_pkg::*;

   localparam int STORE_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   state_type          state_ff, state_in;
   req_payload_type    item_ff, item_in;
   logic [1:0]         step_ff, step_in;
   logic signed [AREA_W-1:0] total_ff, total_in;
   logic signed [AREA_W-1:0] wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in;
   logic               inside_ff, inside_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   point_type          pa, pb, pc, pp, sel_p, sel_q, sel_r;
   logic signed [AREA_W-1:0] area;
   logic               reject;
   logic [NUM_W-1:0]   numer;
   logic               div_start, div_done;
   logic [DEPTH_W-1:0] div_quot;
   logic               on_screen;
   logic [ADDR_W-1:0]  addr;
   logic               rd_en, wr_en, written;
   logic [DEPTH_W-1:0] stored_depth;
   logic               clear_busy;

   // Points of the current item.
   always_comb begin
      pa = '{x: item_ff.vert_a_x, y: item_ff.vert_a_y};
      pb = '{x: item_ff.vert_b_x, y: item_ff.vert_b_y};
      pc = '{x: item_ff.vert_c_x, y: item_ff.vert_c_y};
      pp = '{x: item_ff.pixel_col, y: item_ff.pixel_row};
   end

   // The shared area unit takes the total first, then the three sub-areas.
   always_comb begin
      sel_p = pp;
      sel_q = pb;
      sel_r = pc;
      case (step_ff)
         2'd0: begin
            sel_p = pa;
            sel_q = pb;
            sel_r = pc;
         end
         2'd1: begin
            sel_p = pp;
            sel_q = pb;
            sel_r = pc;
         end
         2'd2: begin
            sel_p = pp;
            sel_q = pc;
            sel_r = pa;
         end
         default: begin
            sel_p = pp;
            sel_q = pa;
            sel_r = pb;
         end
      endcase
   end

   tpd_area u_area (
      .p    (sel_p),
      .q    (sel_q),
      .r    (sel_r),
      .area (area)
   );

   // Inside test, weighted depth sum and store address.
   always_comb begin
      reject = (total_ff < AREA_W'(2)) || wa_ff[AREA_W-1] || wb_ff[AREA_W-1]
               || wc_ff[AREA_W-1];
      numer = NUM_W'(wa_ff[WEIGHT_W-1:0] * item_ff.vert_a_depth)
            + NUM_W'(wb_ff[WEIGHT_W-1:0] * item_ff.vert_b_depth)
            + NUM_W'(wc_ff[WEIGHT_W-1:0] * item_ff.vert_c_depth);
      on_screen = (32'(item_ff.pixel_col) < SCREEN_WIDTH)
               && (32'(item_ff.pixel_row) < SCREEN_HEIGHT);
      addr = ADDR_W'(ADDR_W'(item_ff.pixel_row) * ADDR_W'(SCREEN_WIDTH)
                     + ADDR_W'(item_ff.pixel_col));
   end

   tpd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (total_ff[WEIGHT_W-1:0]),
      .done  (div_done),
      .quot  (div_quot)
   );

   tpd_depth_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (addr),
      .rd_data    (stored_depth),
      .wr_en      (wr_en),
      .wr_addr    (addr),
      .wr_data    (depth_ff),
      .clear_busy (clear_busy)
   );

   // Next state and control for the item sequencer.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      step_in      = step_ff;
      total_in     = total_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      inside_in    = inside_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      written      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = ~clear_busy;
            if (req_valid && !clear_busy) begin
               item_in  = req_data;
               step_in  = 2'd0;
               state_in = ST_AREA;
            end
         end
         ST_AREA: begin
            case (step_ff)
               2'd0:    total_in = area;
               2'd1:    wa_in    = area;
               2'd2:    wb_in    = area;
               default: wc_in    = area;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd3) begin
               state_in = ST_NUMER;
            end
         end
         ST_NUMER: begin
            if (reject) begin
               inside_in = 1'b0;
               depth_in  = '0;
               state_in  = ST_DONE;
            end else begin
               inside_in = 1'b1;
               div_start = 1'b1;
               rd_en     = on_screen;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               depth_in = div_quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               written      = inside_ff && on_screen && (depth_ff > stored_depth);
               wr_en        = written;
               rsp_valid_in = 1'b1;
               rsp_data_in.pixel_written = written;
               rsp_data_in.out_col       = item_ff.pixel_col;
               rsp_data_in.out_row       = item_ff.pixel_row;
               rsp_data_in.out_colour    = written ? item_ff.fill_colour : '0;
               rsp_data_in.out_depth     = depth_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      step_ff     <= step_in;
      total_ff    <= total_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      wc_ff       <= wc_in;
      inside_ff   <= inside_in;
      depth_ff    <= depth_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
